// File: rtl/small_key_value_map_macros.svh
// ----------------------------------------------------------------------------
// small_key_value_map_macros
// assertion macros used by the key/value map top level
// ----------------------------------------------------------------------------
`ifndef SMALL_KEY_VALUE_MAP_MACROS_SVH
`define SMALL_KEY_VALUE_MAP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SKVM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SKVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/skvm_pkg.sv
// ----------------------------------------------------------------------------
// skvm_pkg
// widths, codes and control structs for the key/value map
// ----------------------------------------------------------------------------
package skvm_pkg;

    localparam int CAPACITY   = 16;
    localparam int NS_BITS    = 16;
    localparam int NAME_BITS  = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // request actions
    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_SET    = 3'd1;
    localparam logic [2:0] ACT_GET    = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    // response status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic exec;
        logic move;
        logic load;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_move;
    } dp_stat_t;

endpackage

// File: rtl/skvm_ctrl.sv
// ----------------------------------------------------------------------------
// skvm_ctrl
// request sequencer and response valid for the key/value map
// ----------------------------------------------------------------------------
module skvm_ctrl
    import skvm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_MOVE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;
    logic   can_take;
    logic   take;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign can_take = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign take     = req_valid && can_take;

    assign req_stall = !can_take;
    assign rsp_valid = rsp_valid_reg;

    assign cmd.capture = take;
    assign cmd.lookup  = (state_reg == S_LOOKUP);
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.move    = (state_reg == S_MOVE);
    assign cmd.load    = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: state_next = S_EXEC;
            S_EXEC:   state_next = stat.need_move ? S_MOVE : S_DONE;
            S_MOVE:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = take ? S_LOOKUP : S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// File: rtl/skvm_dp.sv
// ----------------------------------------------------------------------------
// skvm_dp
// key table, value memory, compare and result registers
// ----------------------------------------------------------------------------
module skvm_dp
    import skvm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_cmd_t              cmd,
    output dp_stat_t              stat,
    input  logic                  cfg_write,
    input  logic                  cfg_data,
    input  logic [2:0]            action,
    input  logic [NS_BITS-1:0]    namespace_id,
    input  logic [NAME_BITS-1:0]  name_id,
    input  logic [VALUE_BITS-1:0] value,
    output logic [1:0]            status,
    output logic                  found,
    output logic [VALUE_BITS-1:0] value_out,
    output logic [4:0]            entry_count
);

    // captured request
    logic [2:0]            act_reg;
    logic [NS_BITS-1:0]    ns_reg;
    logic [NAME_BITS-1:0]  nm_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // table state
    logic [NS_BITS-1:0]    key_ns_reg [CAPACITY];
    logic [NAME_BITS-1:0]  key_nm_reg [CAPACITY];
    logic [VALUE_BITS-1:0] val_mem    [CAPACITY];
    logic [VALUE_BITS-1:0] rd_q;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  owns_reg;

    // lookup
    logic [CAPACITY-1:0]   match;
    logic [IDX_W-1:0]      slot_enc;
    logic                  hit_reg;
    logic [IDX_W-1:0]      slot_reg;

    // execute
    logic [IDX_W-1:0]      count_idx;
    logic [IDX_W-1:0]      last_idx;
    logic [CNT_W-1:0]      count_dec;
    logic                  is_full;
    logic                  is_insert;
    logic                  do_append;
    logic                  do_update;
    logic                  do_remove;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    logic [VALUE_BITS-1:0] mem_wd;
    logic [IDX_W-1:0]      mem_ra;

    // results
    logic [1:0]            res_status_reg;
    logic                  res_found_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic [1:0]            res_status_next;
    logic                  res_found_next;
    logic [VALUE_BITS-1:0] res_value_next;
    logic [1:0]            out_status_reg;
    logic                  out_found_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [CNT_W-1:0]      out_count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            ns_reg  <= namespace_id;
            nm_reg  <= name_id;
            val_reg <= value;
        end
    end

    // parallel key compare over occupied slots
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (key_ns_reg[i] == ns_reg)
                       && (key_nm_reg[i] == nm_reg);
        end
    end

    always_comb
    begin
        slot_enc = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                slot_enc = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg  <= |match;
            slot_reg <= slot_enc;
        end
    end

    assign count_dec = count_reg - CNT_W'(1);
    assign count_idx = count_reg[IDX_W-1:0];
    assign last_idx  = count_dec[IDX_W-1:0];
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_insert = ((act_reg == ACT_ADD) || (act_reg == ACT_SET)) && !hit_reg;
    assign do_append = cmd.exec && is_insert && !is_full;
    assign do_update = cmd.exec && (act_reg == ACT_SET) && hit_reg;
    assign do_remove = cmd.exec && (act_reg == ACT_REMOVE) && hit_reg;

    assign stat.need_move = (act_reg == ACT_REMOVE) && hit_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec)
        begin
            if (act_reg == ACT_CLEAR)
            begin
                count_next = '0;
            end
            else if (do_append)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (do_remove)
            begin
                count_next = count_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            owns_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_write)
            begin
                owns_reg <= cfg_data;
            end
        end
    end

    // key table: append at the end, last entry fills the hole on remove
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            key_ns_reg[count_idx] <= ns_reg;
            key_nm_reg[count_idx] <= nm_reg;
        end
        else if (do_remove)
        begin
            key_ns_reg[slot_reg] <= key_ns_reg[last_idx];
            key_nm_reg[slot_reg] <= key_nm_reg[last_idx];
        end
    end

    // value memory: slot read during lookup, last entry read during execute
    assign mem_we = do_append || do_update || cmd.move;
    assign mem_wa = do_append ? count_idx : slot_reg;
    assign mem_wd = cmd.move ? rd_q : val_reg;
    assign mem_ra = cmd.lookup ? slot_enc : last_idx;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            val_mem[mem_wa] <= mem_wd;
        end
        rd_q <= val_mem[mem_ra];
    end

    always_comb
    begin
        res_status_next = ST_OK;
        res_found_next  = 1'b0;
        res_value_next  = '0;
        case (act_reg)
            ACT_ADD:
            begin
                if (hit_reg)
                begin
                    res_status_next = ST_PRESENT;
                    res_found_next  = 1'b1;
                end
                else if (is_full)
                begin
                    res_status_next = ST_FULL;
                end
            end
            ACT_SET:
            begin
                if (hit_reg)
                begin
                    res_found_next = 1'b1;
                end
                else if (is_full)
                begin
                    res_status_next = ST_FULL;
                end
            end
            ACT_GET:
            begin
                res_found_next = hit_reg;
                res_value_next = hit_reg ? rd_q : '0;
            end
            ACT_REMOVE:
            begin
                res_found_next = hit_reg;
                res_value_next = (hit_reg && !owns_reg) ? rd_q : '0;
            end
            default:
            begin
                res_status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            res_value_reg  <= res_value_next;
        end
        if (cmd.load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign value_out   = out_value_reg;
    assign entry_count = 5'(out_count_reg);

endmodule

// File: rtl/small_key_value_map.sv
// a request accepted passes through lookup, execute, move (only when a remove hits and the last
// entry must be moved into the hole) and done before its response is registered
// one request at a time: a new one is taken only in idle or in done, set by the single
// read port of the value memory and the compare-then-write sequence
// reset: entry count and owns_values clear at once; table contents stay undefined, no sweep
// ----------------------------------------------------------------------------
// small_key_value_map
// fixed-capacity map keyed by (namespace, name) with swap-on-remove
// ----------------------------------------------------------------------------
`include "small_key_value_map_macros.svh"

module small_key_value_map
    import skvm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_write,
    input  logic                  cfg_data,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [2:0]            action,
    input  logic [NS_BITS-1:0]    namespace_id,
    input  logic [NAME_BITS-1:0]  name_id,
    input  logic [VALUE_BITS-1:0] value,
    // response channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [1:0]            status,
    output logic                  found,
    output logic [VALUE_BITS-1:0] value_out,
    output logic [4:0]            entry_count
);

    // command and status between the sequencer and the table datapath
    ctl_cmd_t cmd;
    dp_stat_t stat;

    // sequencer: idle -> lookup -> execute -> (move) -> done
    // a new request is taken in done as soon as the response register frees up
    skvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: parallel compare over all occupied slots, value memory with
    // registered read, and the response register that parts the two channels
    skvm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .action       (action),
        .namespace_id (namespace_id),
        .name_id      (name_id),
        .value        (value),
        .status       (status),
        .found        (found),
        .value_out    (value_out),
        .entry_count  (entry_count)
    );

    // count never exceeds the table size
    `SKVM_ASSERT_NOW(a_count_range, rsp_valid, entry_count <= 5'(CAPACITY), "entry count over capacity")
    // a request refused because the table is full never reports a match
    `SKVM_ASSERT_NOW(a_full_not_found, rsp_valid && (status == ST_FULL), !found, "full with found set")
    // an add refused as present always carries found
    `SKVM_ASSERT_NOW(a_present_found, rsp_valid && (status == ST_PRESENT), found, "present without found")
    // one request in flight: the cycle after a request is taken, the channel stalls
    `SKVM_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "request taken back to back")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the small key/value map: a directed table of
// requests, then random phases with small key pools, both config settings,
// random idling on both channels and one long response hold-off
// ----------------------------------------------------------------------------
module tb;
    import skvm_pkg::*;

    // spare action codes, the block answers them without touching the table
    localparam logic [2:0] ACT_SPARE5 = 3'd5;
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int POOL_MAX     = 48;
    localparam int MAX_SHOWN    = 10;
    localparam int PRESSURE_LEN = 300;

    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    typedef struct packed {
        logic [2:0]            action;
        logic [NS_BITS-1:0]    ns;
        logic [NAME_BITS-1:0]  name;
        logic [VALUE_BITS-1:0] val;
    } map_req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic                  found;
        logic [VALUE_BITS-1:0] value_out;
        logic [4:0]            entry_count;
    } map_rsp_t;

    // typed answer travels with its request when the row carries one
    typedef struct packed {
        logic     typed;
        map_rsp_t rsp;
    } rsp_note_t;

    typedef struct {
        int        cfg;
        map_req_t  req;
        bit        typed;
        map_rsp_t  rsp;
    } dir_row_t;

    // dut signals
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic                  cfg_data;
    logic                  req_valid;
    logic                  req_stall;
    logic [2:0]            action;
    logic [NS_BITS-1:0]    namespace_id;
    logic [NAME_BITS-1:0]  name_id;
    logic [VALUE_BITS-1:0] value;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [1:0]            status;
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    logic [4:0]            entry_count;

    // predicted table contents, mirrors the block
    logic [NS_BITS-1:0]    tbl_ns   [0:CAPACITY-1];
    logic [NAME_BITS-1:0]  tbl_name [0:CAPACITY-1];
    logic [VALUE_BITS-1:0] tbl_val  [0:CAPACITY-1];
    int                    tbl_count;
    bit                    tbl_owns;

    map_rsp_t  awaited_responses[$];
    rsp_note_t typed_answers[$];
    dir_row_t  dir_rows[$];

    logic [NS_BITS-1:0]    pool_ns   [0:POOL_MAX-1];
    logic [NAME_BITS-1:0]  pool_name [0:POOL_MAX-1];

    int fail_count;
    int cycles;
    int hold_cycles;
    bit no_idle;

    small_key_value_map u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .namespace_id (namespace_id),
        .name_id      (name_id),
        .value        (value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .found        (found),
        .value_out    (value_out),
        .entry_count  (entry_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit, covers a hung handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // linear search over the occupied slots, -1 on a miss
    function automatic int find_key(input logic [NS_BITS-1:0] ns,
                                    input logic [NAME_BITS-1:0] name);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_ns[i] == ns && tbl_name[i] == name)
                return i;
        end
        return -1;
    endfunction

    // append at the end of the occupied slots, full table refuses
    function automatic logic [1:0] append_key(input map_req_t rq);
        if (tbl_count >= CAPACITY)
            return ST_FULL;
        tbl_ns[tbl_count]   = rq.ns;
        tbl_name[tbl_count] = rq.name;
        tbl_val[tbl_count]  = rq.val;
        tbl_count++;
        return ST_OK;
    endfunction

    // applies one request to the predicted table and returns its response
    function automatic map_rsp_t predict_map_response(input map_req_t rq);
        map_rsp_t r;
        int       hit;
        r   = '0;
        hit = find_key(rq.ns, rq.name);
        case (rq.action)
            ACT_ADD:
            begin
                if (hit >= 0)
                begin
                    r.status = ST_PRESENT;
                    r.found  = 1'b1;
                end
                else
                    r.status = append_key(rq);
            end
            ACT_SET:
            begin
                if (hit >= 0)
                begin
                    tbl_val[hit] = rq.val;
                    r.found      = 1'b1;
                end
                else
                    r.status = append_key(rq);
            end
            ACT_GET:
            begin
                if (hit >= 0)
                begin
                    r.found     = 1'b1;
                    r.value_out = tbl_val[hit];
                end
            end
            ACT_REMOVE:
            begin
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    if (!tbl_owns)
                        r.value_out = tbl_val[hit];
                    tbl_count--;
                    // last entry fills the hole
                    if (hit != tbl_count)
                    begin
                        tbl_ns[hit]   = tbl_ns[tbl_count];
                        tbl_name[hit] = tbl_name[tbl_count];
                        tbl_val[hit]  = tbl_val[tbl_count];
                    end
                end
            end
            ACT_CLEAR:
                tbl_count = 0;
            default:
                ;
        endcase
        r.entry_count = tbl_count[4:0];
        return r;
    endfunction

    // request and response monitor, response side first so a same-edge
    // request never pairs with the response that is leaving
    always @(posedge clk)
    begin : monitor
        map_req_t  rq;
        map_rsp_t  got;
        map_rsp_t  want;
        rsp_note_t note;
        if (rsp_valid && !rsp_stall)
        begin
            got = {status, found, value_out, entry_count};
            if (awaited_responses.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected response: status %0d found %0d value %h count %0d",
                             got.status, got.found, got.value_out, got.entry_count);
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.value_out !== want.value_out ||
                    got.entry_count !== want.entry_count)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display({"mismatch at cycle %0d: status %0d/%0d found %0d/%0d ",
                                  "value %h/%h count %0d/%0d (expected/actual)"},
                                 cycles, want.status, got.status, want.found, got.found,
                                 want.value_out, got.value_out,
                                 want.entry_count, got.entry_count);
                end
            end
        end
        if (req_valid && !req_stall)
        begin
            rq   = {action, namespace_id, name_id, value};
            want = predict_map_response(rq);
            note = typed_answers.pop_front();
            awaited_responses.push_back(note.typed ? note.rsp : want);
        end
    end

    // response side: a random stall before each response, or a long
    // hold-off when the stimulus asks for one
    initial
    begin : rsp_side
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n           = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = no_idle ? 0 : $urandom_range(0, 11);
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
        end
    end

    // offers one request after its gap and holds it until accepted
    task automatic send_request(input map_req_t rq, input bit typed, input map_rsp_t rsp);
        rsp_note_t note;
        int        gap;
        note.typed = typed;
        note.rsp   = rsp;
        gap        = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        action       <= rq.action;
        namespace_id <= rq.ns;
        name_id      <= rq.name;
        value        <= rq.val;
        typed_answers.push_back(note);
        do @(posedge clk); while (req_stall);
    endtask

    // register write, only once every response is back
    task automatic write_owns(input bit owns);
        req_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= owns;
        @(posedge clk);
        cfg_write <= 1'b0;
        tbl_owns = owns;
    endtask

    task automatic add_row(input int cfg, input logic [2:0] act, input logic [15:0] ns,
                           input logic [31:0] name, input logic [31:0] val, input bit typed,
                           input logic [1:0] st, input logic fnd, input logic [31:0] vo,
                           input logic [4:0] cnt);
        dir_row_t row;
        row.cfg   = cfg;
        row.req   = {act, ns, name, val};
        row.typed = typed;
        row.rsp   = {st, fnd, vo, cnt};
        dir_rows.push_back(row);
    endtask

    // random request drawn from the phase's key pool, a few stray keys
    function automatic map_req_t random_request(input mix_t mix, input int pool_size);
        map_req_t rq;
        int       r;
        int       k;
        int       ins_w;
        int       rem_w;
        r     = $urandom_range(0, 99);
        ins_w = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 45;
        rem_w = (mix == MIX_DRAIN) ? 45 : 12;
        if (r < 3)
            rq.action = ACT_CLEAR;
        else if (r < 6)
            rq.action = 3'($urandom_range(ACT_SPARE5, ACT_SPARE7));
        else if (r < 6 + ins_w)
            rq.action = $urandom_range(0, 1) ? ACT_ADD : ACT_SET;
        else if (r < 6 + ins_w + rem_w)
            rq.action = ACT_REMOVE;
        else
            rq.action = ACT_GET;
        k = $urandom_range(0, pool_size - 1);
        if ($urandom_range(0, 99) < 6)
        begin
            rq.ns   = NS_BITS'($urandom);
            rq.name = NAME_BITS'($urandom);
        end
        else
        begin
            rq.ns   = pool_ns[k];
            rq.name = pool_name[k];
        end
        case ($urandom_range(0, 15))
            0:       rq.val = '0;
            1:       rq.val = '1;
            default: rq.val = VALUE_BITS'($urandom);
        endcase
        return rq;
    endfunction

    initial
    begin : stimulus
        map_req_t rq;
        mix_t     mix;
        int       pool_size;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_data     = 1'b0;
        req_valid    = 1'b0;
        action       = ACT_ADD;
        namespace_id = '0;
        name_id      = '0;
        value        = '0;
        rsp_stall    = 1'b0;
        fail_count   = 0;
        cycles       = 0;
        hold_cycles  = 0;
        no_idle      = 1'b0;
        tbl_count    = 0;
        tbl_owns     = 1'b0;

        // directed requests: cfg column (-1 = leave register), request, typed answer
        add_row(-1, ACT_GET,    16'h0000, 32'h0000_0000, 32'h0, 1, ST_OK, 0, 32'h0, 5'd0);
        add_row(-1, ACT_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1, ST_OK, 0, 32'h0, 5'd0);
        add_row(-1, ACT_ADD,    16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                ST_OK, 0, 32'h0, 5'd1);
        // add of a present key is refused
        add_row(-1, ACT_ADD,    16'hFFFF, 32'hFFFF_FFFF, 32'h5, 1, ST_PRESENT, 1, 32'h0, 5'd1);
        add_row(-1, ACT_GET,    16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1,
                ST_OK, 1, 32'hFFFF_FFFF, 5'd1);
        add_row(-1, ACT_ADD,    16'h0000, 32'h0000_0000, 32'h0, 1, ST_OK, 0, 32'h0, 5'd2);
        // set of a present key overwrites and reports it found
        add_row(-1, ACT_SET,    16'h0000, 32'h0000_0000, 32'h1234_5678, 1,
                ST_OK, 1, 32'h0, 5'd2);
        add_row(-1, ACT_SET,    16'h0001, 32'h0000_0002, 32'hCAFE_0003, 0, 0, 0, 0, 0);
        add_row(-1, ACT_GET,    16'h0000, 32'h0000_0000, 32'h0, 0, 0, 0, 0, 0);
        // spare actions leave the table alone
        add_row(-1, ACT_SPARE5, 16'h8000, 32'h8000_0000, 32'h8000_0000, 1,
                ST_OK, 0, 32'h0, 5'd3);
        add_row(-1, ACT_SPARE6, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                ST_OK, 0, 32'h0, 5'd3);
        add_row(-1, ACT_SPARE7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                ST_OK, 0, 32'h0, 5'd3);
        // remove from slot zero pulls the last entry down
        add_row(-1, ACT_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1,
                ST_OK, 1, 32'hFFFF_FFFF, 5'd2);
        add_row(-1, ACT_GET,    16'h0001, 32'h0000_0002, 32'h0, 0, 0, 0, 0, 0);
        // same namespace, other name misses
        add_row(-1, ACT_GET,    16'h0001, 32'h0000_0003, 32'h0, 0, 0, 0, 0, 0);
        add_row(-1, ACT_CLEAR,  16'h1234, 32'h5678_9ABC, 32'h0, 1, ST_OK, 0, 32'h0, 5'd0);
        // owned values: remove hands back nothing
        add_row(1,  ACT_ADD,    16'h0007, 32'h0000_0009, 32'hA5A5_A5A5, 1,
                ST_OK, 0, 32'h0, 5'd1);
        add_row(-1, ACT_REMOVE, 16'h0007, 32'h0000_0009, 32'h0, 1, ST_OK, 1, 32'h0, 5'd0);
        add_row(-1, ACT_GET,    16'h0007, 32'h0000_0009, 32'h0, 1, ST_OK, 0, 32'h0, 5'd0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg >= 0)
                write_owns(dir_rows[i].cfg[0]);
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        end

        // random phases: each with its own key pool, mix and register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_owns(1'(ph % 2));
            case ($urandom_range(0, 4))
                0:       pool_size = 2;
                1:       pool_size = 6;
                2:       pool_size = 16;
                3:       pool_size = 24;
                default: pool_size = POOL_MAX;
            endcase
            if (ph == 0)
                pool_size = POOL_MAX;
            for (int k = 0; k < POOL_MAX; k++)
            begin
                pool_ns[k]   = NS_BITS'($urandom);
                pool_name[k] = NAME_BITS'($urandom);
                // neighbors that share one half of the key
                if (k > 0 && $urandom_range(0, 3) == 0)
                begin
                    if ($urandom_range(0, 1))
                        pool_ns[k] = pool_ns[k-1];
                    else
                        pool_name[k] = pool_name[k-1];
                end
            end
            pool_ns[0]   = '1;
            pool_name[0] = '0;
            mix = (ph % 3 == 0) ? MIX_FILL : (ph % 3 == 1) ? MIX_DRAIN : MIX_EVEN;
            // back-to-back stretches with no idling on either side
            no_idle = (ph == 2 || ph == 5);
            // the response side holds off while requests keep coming
            if (ph == 3)
                hold_cycles = PRESSURE_LEN;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                rq = random_request(mix, pool_size);
                send_request(rq, 1'b0, '0);
            end
        end
        req_valid <= 1'b0;
        no_idle = 1'b0;

        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && awaited_responses.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: small_key_value_map.f
+incdir+rtl
rtl/skvm_pkg.sv
rtl/skvm_ctrl.sv
rtl/skvm_dp.sv
rtl/small_key_value_map.sv
tb/tb.sv
